[design/usbc_pkg.sv]
// ----------------------------------------------------------------------------
// usbc_pkg
// Shared types, codes and constants of the endpoint-zero control engine.
// ----------------------------------------------------------------------------
`default_nettype none
package usbc_pkg;

  localparam int unsigned Ep0PacketSize = 8;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [7:0] SerialLen = 8'd26;
  localparam logic [7:0] NoRequest = 8'hFF;

  localparam logic [1:0] OpSetup = 2'd0;
  localparam logic [1:0] OpIn    = 2'd1;
  localparam logic [1:0] OpOut   = 2'd2;
  localparam logic [1:0] OpReset = 2'd3;

  localparam logic [1:0] HsAck   = 2'd0;
  localparam logic [1:0] HsStall = 2'd1;
  localparam logic [1:0] HsNak   = 2'd2;
  localparam logic [1:0] HsNone  = 2'd3;

  localparam logic [7:0] ReqGetStatus = 8'd0;
  localparam logic [7:0] ReqClrFeat   = 8'd1;
  localparam logic [7:0] ReqSetFeat   = 8'd3;
  localparam logic [7:0] ReqSetAddr   = 8'd5;
  localparam logic [7:0] ReqGetDesc   = 8'd6;
  localparam logic [7:0] ReqGetCfg    = 8'd8;
  localparam logic [7:0] ReqSetCfg    = 8'd9;
  localparam logic [7:0] ReqGetIf     = 8'd10;
  localparam logic [7:0] ReqSetIf     = 8'd11;

  localparam logic [CfgIdxW-1:0] RegDevLen  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCfgLen  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLangLen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegProdLen = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepLen  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegChipId  = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  rx_length;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
  } event_t;

  typedef struct packed {
    logic       kind;
    logic       byte_from_rom;
    logic [7:0] data_byte;
    logic [2:0] rom_select;
    logic [7:0] rom_offset;
    logic [1:0] handshake;
    logic [3:0] packet_length;
    logic       tx_toggle;
    logic       address_update;
    logic [6:0] new_address;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  function automatic logic [7:0] hex_of(input logic [3:0] v);
    hex_of = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

endpackage
`default_nettype wire

[design/usbc_stream_if.sv]
// ----------------------------------------------------------------------------
// usbc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface usbc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/usbc_serial_gen.sv]
// ----------------------------------------------------------------------------
// usbc_serial_gen
// Generates one byte of the serial string descriptor from its index.
// ----------------------------------------------------------------------------
`default_nettype none
module usbc_serial_gen (
  input  wire logic [7:0]  idx_i,
  input  wire logic [39:0] chip_id_i,
  output logic      [7:0]  byte_o
);
  import usbc_pkg::*;

  logic [6:0] ch;
  logic [6:0] cd;
  logic [5:0] kb;
  logic [7:0] idb;

  always_comb begin
    ch = idx_i[7:1] - 7'd1;
    cd = ch - 7'd2;
    kb = (cd[6:1] > 6'd4) ? 6'd4 : cd[6:1];
    case (kb[2:0])
      3'd0: idb = chip_id_i[39:32];
      3'd1: idb = chip_id_i[31:24];
      3'd2: idb = chip_id_i[23:16];
      3'd3: idb = chip_id_i[15:8];
      default: idb = chip_id_i[7:0];
    endcase
    if (idx_i == 8'd0) byte_o = SerialLen;
    else if (idx_i == 8'd1) byte_o = 8'd3;
    else if (idx_i[0]) byte_o = 8'd0;
    else if (ch == 7'd0) byte_o = 8'h43;
    else if (ch == 7'd1) byte_o = 8'h4B;
    else byte_o = hex_of(cd[0] ? idb[3:0] : idb[7:4]);
  end
endmodule
`default_nettype wire

[design/usb_control_endpoint_handler_unit.sv]
// ----------------------------------------------------------------------------
// usb_control_endpoint_handler_unit
// Endpoint-zero standard request engine with descriptor packet sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  evt      | in        | event_t: operation and setup fields
//  res      | out       | result_t: data bytes, then one handshake item
//  cfg      | in        | cfg_t: register index and write data
//
// An event is decoded in the cycle it is accepted. Then one item is emitted
// per cycle while the output register is free, and the engine goes back to
// idle once the handshake item has been taken. The output stage stalls on
// res.ready; no new event is taken until the handshake item of the current
// one has been handed over. Reset clears all protocol state.
// ----------------------------------------------------------------------------
`default_nettype none
module usb_control_endpoint_handler_unit #(
  parameter int unsigned EP0_PACKET_SIZE = usbc_pkg::Ep0PacketSize
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  usbc_stream_if.sink   evt,
  usbc_stream_if.source res,
  usbc_stream_if.sink   cfg
);
  import usbc_pkg::*;

  localparam int unsigned PktMax = (EP0_PACKET_SIZE < 8) ? EP0_PACKET_SIZE : 8;
  localparam logic [15:0] PktMaxW = 16'(PktMax);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StData = 3'b010,
    StHs   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [7:0] dev_len_q, cfg_len_q, lang_len_q, prod_len_q, rep_len_q;
  logic [39:0] chip_id_q;

  logic [15:0] rem_q, rem_d;
  logic [7:0]  act_q, act_d;
  logic        ser_q, ser_d;
  logic [2:0]  sel_q, sel_d;
  logic [7:0]  off_q, off_d;
  logic        conf_q, conf_d;
  logic [1:0]  halt_q, halt_d;
  logic [6:0]  addr_q, addr_d;
  logic        tog_q, tog_d;
  logic [1:0]  resp_q, resp_d;

  // Per-event sequencing: bytes left in packet, and the pending handshake.
  logic [3:0]  cnt_q, cnt_d;
  logic        gen_q, gen_d;      // generated bytes (status/config)
  logic [7:0]  g0_q, g0_d;        // first generated byte
  logic        first_q, first_d;
  result_t     hs_q, hs_d;

  result_t     out_q, out_d;
  logic        ov_q, ov_d;

  logic [7:0]  ser_byte;

  usbc_serial_gen u_ser (.idx_i(off_q), .chip_id_i(chip_id_q), .byte_o(ser_byte));

  assign evt.ready = (state_q == StIdle);
  assign cfg.ready = 1'b1;
  assign res.valid = ov_q;
  assign res.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_len_q <= 8'd18; cfg_len_q <= 8'd34; lang_len_q <= 8'd4;
      prod_len_q <= 8'd24; rep_len_q <= 8'd63; chip_id_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        RegDevLen:  dev_len_q  <= cfg.payload.data[7:0];
        RegCfgLen:  cfg_len_q  <= cfg.payload.data[7:0];
        RegLangLen: lang_len_q <= cfg.payload.data[7:0];
        RegProdLen: prod_len_q <= cfg.payload.data[7:0];
        RegRepLen:  rep_len_q  <= cfg.payload.data[7:0];
        RegChipId:  chip_id_q  <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  function automatic result_t mk_hs(input logic [1:0] h, input logic [3:0] n,
                                    input logic t, input logic au,
                                    input logic [6:0] a);
    result_t r;
    r = '0;
    r.kind = 1'b1; r.handshake = h; r.packet_length = n; r.tx_toggle = t;
    r.address_update = au; r.new_address = au ? a : 7'd0; r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    event_t e;
    logic stall, okd;
    logic [7:0] dl, rt, rq, vh, vl, ih, il;
    logic [15:0] iw, rl;
    logic [3:0] n;
    result_t d;
    e = evt.payload;
    rt = e.request_type; rq = e.request_code;
    vh = e.value_word[15:8]; vl = e.value_word[7:0];
    ih = e.index_word[15:8]; il = e.index_word[7:0]; iw = e.index_word;
    rl = e.length_word;
    stall = 1'b0; okd = 1'b0; dl = 8'd0; n = 4'd0; d = '0;

    state_d = state_q;
    rem_d = rem_q; act_d = act_q; ser_d = ser_q; sel_d = sel_q; off_d = off_q;
    conf_d = conf_q; halt_d = halt_q; addr_d = addr_q; tog_d = tog_q;
    resp_d = resp_q; cnt_d = cnt_q; gen_d = gen_q; g0_d = g0_q;
    first_d = first_q; hs_d = hs_q; out_d = out_q; ov_d = ov_q;

    if (ov_q && res.ready) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (evt.valid) begin
          cnt_d = 4'd0; gen_d = 1'b0; g0_d = 8'd0; first_d = 1'b1;
          state_d = StData;
          case (e.operation)
            OpSetup: begin
              tog_d = 1'b1;
              if (e.rx_length != 7'd8) stall = 1'b1;
              else begin
                rem_d = rl; act_d = rq; ser_d = 1'b0; off_d = 8'd0;
                if ((rt & 8'h60) != 8'd0) stall = 1'b1;
                else begin
                  case (rq)
                    ReqGetDesc: begin
                      okd = 1'b1;
                      if (vh == 8'd1) begin sel_d = 3'd0; dl = dev_len_q; end
                      else if (vh == 8'd2) begin sel_d = 3'd1; dl = cfg_len_q; end
                      else if (vh == 8'd3) begin
                        if (vl == 8'd0) begin sel_d = 3'd2; dl = lang_len_q; end
                        else if (vl == 8'd1 || vl == 8'd2) begin
                          sel_d = 3'd3; dl = prod_len_q;
                        end else if (vl == 8'd3) begin
                          sel_d = 3'd0; ser_d = 1'b1; dl = SerialLen;
                        end else stall = 1'b1;
                      end else if (vh == 8'h22 && vl == 8'd0) begin
                        sel_d = 3'd4; dl = rep_len_q;
                      end else stall = 1'b1;
                      if (!stall) begin
                        if (rl > {8'd0, dl}) rem_d = {8'd0, dl};
                        n = (rem_d >= PktMaxW) ? 4'(PktMax) : rem_d[3:0];
                      end
                    end
                    ReqSetAddr: rem_d = {8'd0, vl};
                    ReqGetCfg: begin
                      if (rl != 16'd0) begin
                        n = 4'd1; gen_d = 1'b1; g0_d = {7'd0, conf_q};
                      end
                    end
                    ReqSetCfg: begin
                      if (rt != 8'd0 || vh != 8'd0 || vl > 8'd1 || ih != 8'd0 ||
                          il != 8'd0 || rl != 16'd0) stall = 1'b1;
                      else begin conf_d = vl[0]; halt_d = 2'b00; end
                    end
                    ReqGetIf, ReqSetIf: ;
                    ReqClrFeat, ReqSetFeat: begin
                      if (rt != 8'h02 || vh != 8'd0 || vl != 8'd0 || ih != 8'd0 ||
                          rl != 16'd0 || !conf_q || (il != 8'h81 && il != 8'h01))
                        stall = 1'b1;
                      else if (rq == ReqSetFeat)
                        halt_d = halt_q | ((il == 8'h81) ? 2'b10 : 2'b01);
                      else halt_d = halt_q & ~((il == 8'h81) ? 2'b10 : 2'b01);
                    end
                    ReqGetStatus: begin
                      if (vh != 8'd0 || vl != 8'd0 || rl != 16'd2) stall = 1'b1;
                      else if (rt == 8'h80) begin
                        if (iw != 16'd0) stall = 1'b1;
                      end else if (rt == 8'h81) begin
                        if (!conf_q || iw != 16'd0) stall = 1'b1;
                      end else if (rt == 8'h82) begin
                        if (iw == 16'h81 || iw == 16'h01) begin
                          if (!conf_q) stall = 1'b1;
                          else g0_d = {7'd0, (iw == 16'h81) ? halt_q[1] : halt_q[0]};
                        end else if (iw != 16'h80 && iw != 16'h00) stall = 1'b1;
                      end else stall = 1'b1;
                      if (!stall) begin n = 4'd2; gen_d = 1'b1; end
                    end
                    default: stall = 1'b1;
                  endcase
                end
              end
              if (stall) begin
                act_d = NoRequest; resp_d = HsStall; n = 4'd0;
                hs_d = mk_hs(HsStall, 4'd0, 1'b1, 1'b0, 7'd0);
              end else begin
                resp_d = HsAck;
                hs_d = mk_hs(HsAck, n, 1'b1, 1'b0, 7'd0);
                if (okd) rem_d = rem_d - {12'd0, n};
              end
              cnt_d = n;
            end
            OpIn: begin
              if (act_q == ReqGetDesc) begin
                n = (rem_q >= PktMaxW) ? 4'(PktMax) : rem_q[3:0];
                rem_d = rem_q - {12'd0, n};
                tog_d = ~tog_q;
                cnt_d = n;
                hs_d = mk_hs(resp_q, n, ~tog_q, 1'b0, 7'd0);
              end else begin
                resp_d = HsNak; tog_d = 1'b0;
                if (act_q == ReqSetAddr) begin
                  addr_d = rem_q[6:0];
                  hs_d = mk_hs(HsNak, 4'd0, 1'b0, 1'b1, rem_q[6:0]);
                end else hs_d = mk_hs(HsNak, 4'd0, 1'b0, 1'b0, 7'd0);
              end
            end
            OpOut: begin
              resp_d = (resp_q == HsAck) ? HsNak : resp_q;
              hs_d = mk_hs(resp_d, 4'd0, tog_q, 1'b0, 7'd0);
            end
            default: begin
              addr_d = 7'd0; conf_d = 1'b0; halt_d = 2'b00;
              resp_d = HsNak; tog_d = 1'b0;
              hs_d = mk_hs(HsNak, 4'd0, 1'b0, 1'b1, 7'd0);
            end
          endcase
        end
      end
      StData: begin
        if (!ov_d) begin
          if (cnt_q == 4'd0) begin
            out_d = hs_q; ov_d = 1'b1; state_d = StHs;
          end else begin
            d.handshake = HsNone;
            if (gen_q) begin
              d.data_byte = first_q ? g0_q : 8'd0;
            end else if (ser_q) begin
              d.data_byte = ser_byte;
              off_d = off_q + 8'd1;
            end else begin
              d.byte_from_rom = 1'b1; d.rom_select = sel_q; d.rom_offset = off_q;
              off_d = off_q + 8'd1;
            end
            out_d = d; ov_d = 1'b1;
            first_d = 1'b0;
            cnt_d = cnt_q - 4'd1;
          end
        end
      end
      StHs: begin
        if (!ov_d) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rem_q <= '0; act_q <= NoRequest; ser_q <= 1'b0; sel_q <= '0; off_q <= '0;
      conf_q <= 1'b0; halt_q <= '0; addr_q <= '0; tog_q <= 1'b1; resp_q <= HsNak;
      cnt_q <= '0; gen_q <= 1'b0; first_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q <= rem_d; act_q <= act_d; ser_q <= ser_d; sel_q <= sel_d; off_q <= off_d;
      conf_q <= conf_d; halt_q <= halt_d; addr_q <= addr_d; tog_q <= tog_d;
      resp_q <= resp_d; cnt_q <= cnt_d; gen_q <= gen_d; first_q <= first_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g0_q <= g0_d; hs_q <= hs_d; out_q <= out_d;
  end
endmodule
`default_nettype wire

[dv/usbc_ep0_checker.sv]
// ----------------------------------------------------------------------------
// usbc_ep0_checker
// Watches the event, result and register channels of the endpoint-zero engine,
// predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module usbc_ep0_checker
  import usbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    evt_valid_i,
  input  logic    evt_ready_i,
  input  event_t  evt_i,
  input  logic    res_valid_i,
  input  logic    res_ready_i,
  input  result_t res_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  cfg_t    cfg_i,
  output int      fail_count_o,
  output int      pending_o,
  output int      results_seen_o
);

  // Register shadow.
  logic [7:0]  dev_len_q, cfg_len_q, lang_len_q, prod_len_q, rep_len_q;
  logic [39:0] chip_id_q;

  // Protocol state shadow.
  logic [15:0] remain_q;
  logic [7:0]  req_q;
  logic        serial_q;
  logic [2:0]  sel_q;
  logic [7:0]  off_q;
  logic        configured_q;
  logic [1:0]  halts_q;
  logic [6:0]  addr_q;
  logic        toggle_q;
  logic [1:0]  resp_q;

  result_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [7:0] id_byte_at(input logic [7:0] k);
    logic [7:0] kk;
    kk = (k > 8'd4) ? 8'd4 : k;
    return chip_id_q[8 * (4 - kk) +: 8];
  endfunction

  function automatic logic [7:0] to_hex(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + v) : (8'h41 + v - 8'd10);
  endfunction

  function automatic logic [7:0] serial_char(input logic [7:0] idx);
    logic [7:0] ch, v;
    if (idx == 0) return SerialLen;
    if (idx == 1) return 8'd3;
    if (idx[0]) return 8'd0;
    ch = (idx - 8'd2) >> 1;
    if (ch == 0) return 8'h43;
    if (ch == 1) return 8'h4B;
    ch = ch - 8'd2;
    v = id_byte_at(ch >> 1);
    return to_hex(ch[0] ? v[3:0] : v[7:4]);
  endfunction

  task automatic push_byte(input logic rom, input logic [7:0] d, input logic [2:0] s,
                           input logic [7:0] o);
    result_t r;
    r = '0;
    r.byte_from_rom = rom;
    r.data_byte = rom ? 8'd0 : d;
    r.rom_select = rom ? s : 3'd0;
    r.rom_offset = rom ? o : 8'd0;
    r.handshake = HsNone;
    expected_results.push_back(r);
  endtask

  task automatic push_end(input logic [1:0] hs, input logic [3:0] plen, input logic tog,
                          input logic au, input logic [6:0] a);
    result_t r;
    r = '0;
    r.kind = 1'b1;
    r.handshake = hs;
    r.packet_length = plen;
    r.tx_toggle = tog;
    r.address_update = au;
    r.new_address = au ? a : 7'd0;
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // Queues the expected bytes of the next descriptor packet and returns its byte count.
  task automatic next_packet(output logic [3:0] n);
    logic [7:0] o;
    n = (remain_q >= 16'd8) ? 4'd8 : remain_q[3:0];
    for (int i = 0; i < n; i++) begin
      o = off_q + i[7:0];
      if (serial_q) push_byte(1'b0, serial_char(o), 3'd0, 8'd0);
      else push_byte(1'b1, 8'd0, sel_q, o);
    end
    remain_q = remain_q - {12'd0, n};
    off_q = off_q + {4'd0, n};
  endtask

  task automatic predict_setup(input event_t e);
    logic [7:0] rt, rq, vh, vl, ih, il, dl, st;
    logic stall;
    logic [3:0] len;
    rt = e.request_type; rq = e.request_code;
    vh = e.value_word[15:8]; vl = e.value_word[7:0];
    ih = e.index_word[15:8]; il = e.index_word[7:0];
    stall = 1'b0; len = 4'd0; dl = 8'd0; st = 8'd0;
    if (e.rx_length != 7'd8) begin
      stall = 1'b1;
    end else begin
      remain_q = e.length_word;
      req_q = rq;
      serial_q = 1'b0;
      off_q = 8'd0;
      if ((rt & 8'h60) != 0) begin
        stall = 1'b1;
      end else if (rq == ReqGetDesc) begin
        if (vh == 8'd1) begin
          sel_q = 3'd0; dl = dev_len_q;
        end else if (vh == 8'd2) begin
          sel_q = 3'd1; dl = cfg_len_q;
        end else if (vh == 8'd3) begin
          if (vl == 0) begin
            sel_q = 3'd2; dl = lang_len_q;
          end else if (vl == 1 || vl == 2) begin
            sel_q = 3'd3; dl = prod_len_q;
          end else if (vl == 3) begin
            sel_q = 3'd0; serial_q = 1'b1; dl = SerialLen;
          end else stall = 1'b1;
        end else if (vh == 8'h22 && vl == 0) begin
          sel_q = 3'd4; dl = rep_len_q;
        end else stall = 1'b1;
        if (!stall) begin
          if (remain_q > {8'd0, dl}) remain_q = {8'd0, dl};
          next_packet(len);
        end
      end else if (rq == ReqSetAddr) begin
        remain_q = {8'd0, vl};
      end else if (rq == ReqGetCfg) begin
        if (remain_q >= 1) begin
          push_byte(1'b0, {7'd0, configured_q}, 3'd0, 8'd0);
          len = 4'd1;
        end
      end else if (rq == ReqSetCfg) begin
        if (rt != 0 || vh != 0 || vl > 1 || ih != 0 || il != 0 || remain_q != 0) stall = 1'b1;
        else begin
          configured_q = vl[0]; halts_q = 2'b00;
        end
      end else if (rq == ReqGetIf || rq == ReqSetIf) begin
        // Accepted with an empty reply.
      end else if (rq == ReqClrFeat || rq == ReqSetFeat) begin
        if (rt != 8'h02 || vh != 0 || vl != 0 || ih != 0 || remain_q != 0 || !configured_q ||
            (il != 8'h81 && il != 8'h01)) stall = 1'b1;
        else if (rq == ReqSetFeat) halts_q = halts_q | ((il == 8'h81) ? 2'b10 : 2'b01);
        else halts_q = halts_q & ~((il == 8'h81) ? 2'b10 : 2'b01);
      end else if (rq == ReqGetStatus) begin
        if (vh != 0 || vl != 0 || remain_q != 16'd2) stall = 1'b1;
        else if (rt == 8'h80) begin
          if (e.index_word != 0) stall = 1'b1;
        end else if (rt == 8'h81) begin
          if (!configured_q || e.index_word != 0) stall = 1'b1;
        end else if (rt == 8'h82) begin
          if (e.index_word == 16'h81 || e.index_word == 16'h01) begin
            if (!configured_q) stall = 1'b1;
            else st = {7'd0, (halts_q & ((e.index_word == 16'h81) ? 2'b10 : 2'b01)) != 2'b00};
          end else if (e.index_word != 16'h80 && e.index_word != 16'h00) stall = 1'b1;
        end else stall = 1'b1;
        if (!stall) begin
          push_byte(1'b0, st, 3'd0, 8'd0);
          push_byte(1'b0, 8'd0, 3'd0, 8'd0);
          len = 4'd2;
        end
      end else begin
        stall = 1'b1;
      end
    end
    toggle_q = 1'b1;
    if (stall) begin
      // A stall drops any bytes queued for this event.
      while (expected_results.size() > 0 && expected_results[$].kind == 1'b0)
        void'(expected_results.pop_back());
      req_q = NoRequest;
      resp_q = HsStall;
      push_end(HsStall, 4'd0, 1'b1, 1'b0, 7'd0);
    end else begin
      resp_q = HsAck;
      push_end(HsAck, len, 1'b1, 1'b0, 7'd0);
    end
  endtask

  task automatic predict_event(input event_t e);
    logic [3:0] n;
    case (e.operation)
      OpSetup: predict_setup(e);
      OpIn: begin
        if (req_q == ReqGetDesc) begin
          next_packet(n);
          toggle_q = ~toggle_q;
          push_end(resp_q, n, toggle_q, 1'b0, 7'd0);
        end else begin
          resp_q = HsNak;
          toggle_q = 1'b0;
          if (req_q == ReqSetAddr) begin
            addr_q = remain_q[6:0];
            push_end(HsNak, 4'd0, 1'b0, 1'b1, addr_q);
          end else push_end(HsNak, 4'd0, 1'b0, 1'b0, 7'd0);
        end
      end
      OpOut: begin
        if (resp_q == HsAck) resp_q = HsNak;
        push_end(resp_q, 4'd0, toggle_q, 1'b0, 7'd0);
      end
      default: begin
        addr_q = 7'd0; configured_q = 1'b0; halts_q = 2'b00;
        resp_q = HsNak; toggle_q = 1'b0;
        push_end(HsNak, 4'd0, 1'b0, 1'b1, 7'd0);
      end
    endcase
  endtask

  task automatic compare_result(input result_t got);
    result_t w;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %h", got);
      fail_count_o++;
      return;
    end
    w = expected_results.pop_front();
    if (got.kind !== w.kind) $error("kind exp %0d got %0d", w.kind, got.kind);
    if (got.byte_from_rom !== w.byte_from_rom)
      $error("byte_from_rom exp %0d got %0d", w.byte_from_rom, got.byte_from_rom);
    if (got.data_byte !== w.data_byte)
      $error("data_byte exp %h got %h", w.data_byte, got.data_byte);
    if (got.rom_select !== w.rom_select)
      $error("rom_select exp %0d got %0d", w.rom_select, got.rom_select);
    if (got.rom_offset !== w.rom_offset)
      $error("rom_offset exp %0d got %0d", w.rom_offset, got.rom_offset);
    if (got.handshake !== w.handshake)
      $error("handshake exp %0d got %0d", w.handshake, got.handshake);
    if (got.packet_length !== w.packet_length)
      $error("packet_length exp %0d got %0d", w.packet_length, got.packet_length);
    if (got.tx_toggle !== w.tx_toggle)
      $error("tx_toggle exp %0d got %0d", w.tx_toggle, got.tx_toggle);
    if (got.address_update !== w.address_update)
      $error("address_update exp %0d got %0d", w.address_update, got.address_update);
    if (got.new_address !== w.new_address)
      $error("new_address exp %0d got %0d", w.new_address, got.new_address);
    if (got.last !== w.last) $error("last exp %0d got %0d", w.last, got.last);
    if (got !== w) fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_len_q <= 8'd18; cfg_len_q <= 8'd34; lang_len_q <= 8'd4;
      prod_len_q <= 8'd24; rep_len_q <= 8'd63; chip_id_q <= '0;
      remain_q <= '0; req_q <= NoRequest; serial_q <= 1'b0; sel_q <= '0; off_q <= '0;
      configured_q <= 1'b0; halts_q <= '0; addr_q <= '0; toggle_q <= 1'b1;
      resp_q <= HsNak;
      expected_results.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      // The result is compared before a new event adds expectations.
      if (res_valid_i && res_ready_i) begin
        compare_result(res_i);
        results_seen_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_i.index)
          RegDevLen:  dev_len_q = cfg_i.data[7:0];
          RegCfgLen:  cfg_len_q = cfg_i.data[7:0];
          RegLangLen: lang_len_q = cfg_i.data[7:0];
          RegProdLen: prod_len_q = cfg_i.data[7:0];
          RegRepLen:  rep_len_q = cfg_i.data[7:0];
          RegChipId:  chip_id_q = cfg_i.data;
          default: ;
        endcase
      end
      if (evt_valid_i && evt_ready_i) predict_event(evt_i);
    end
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the endpoint-zero control engine: directed
// requests, then mostly well-formed control transfers with random content,
// under random stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import usbc_pkg::*;

  // Random iterations; most of them bring a few IN events along.
  localparam int RandomEvents = 150;
  localparam int IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;

  usbc_stream_if #(.T(event_t))  evt_ch ();
  usbc_stream_if #(.T(result_t)) res_ch ();
  usbc_stream_if #(.T(cfg_t))    cfg_ch ();

  int fail_count, pending, results_seen;
  int events_sent, cfg_writes;
  int idle_cycles;
  bit stall_enable;   // Random stalls on the result side.
  bit long_hold;      // Receiver holds off for a long stretch.

  usb_control_endpoint_handler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt    (evt_ch.sink),
    .res    (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  usbc_ep0_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_valid_i    (evt_ch.valid),
    .evt_ready_i    (evt_ch.ready),
    .evt_i          (evt_ch.payload),
    .res_valid_i    (res_ch.valid),
    .res_ready_i    (res_ch.ready),
    .res_i          (res_ch.payload),
    .cfg_valid_i    (cfg_ch.valid),
    .cfg_ready_i    (cfg_ch.ready),
    .cfg_i          (cfg_ch.payload),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random bursts of back-pressure, plus one long hold-off that is
  // counted here while the sender keeps offering transactions.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("usb_control_endpoint_handler_unit test failed");
        $finish;
      end
    end
  end

  // Valid stays high into the next transaction unless a random gap drops it; wait_quiet drops it too.
  task automatic send_event(input event_t e, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    evt_ch.payload <= e;
    evt_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!evt_ch.ready);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    evt_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_ch.payload <= '{index: idx, data: d};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic event_t setup_pkt(input logic [7:0] rt, input logic [7:0] rq,
                                       input logic [15:0] v, input logic [15:0] ix,
                                       input logic [15:0] len);
    return '{operation: OpSetup, rx_length: 7'd8, request_type: rt, request_code: rq,
             value_word: v, index_word: ix, length_word: len};
  endfunction

  function automatic event_t plain_op(input logic [1:0] op);
    event_t e;
    e = event_t'({$urandom, $urandom, $urandom});
    e.operation = op;
    return e;
  endfunction

  // A standard request with random but plausible fields, mostly well-formed.
  function automatic event_t random_request();
    logic [15:0] desc_vals [6];
    logic [15:0] len;
    desc_vals = '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0303, 16'h2200};
    len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
    case ($urandom_range(0, 8))
      0, 1, 2: return setup_pkt(8'h80, ReqGetDesc,
                                desc_vals[$urandom_range(0, 5)] ^
                                (($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0), 0, len);
      3: return setup_pkt(8'h00, ReqSetAddr, 16'($urandom), 0, 0);
      4: return setup_pkt(8'h00, ReqSetCfg, 16'($urandom_range(0, 2)), 0, 0);
      5: return setup_pkt(8'h02, ($urandom_range(0, 1) != 0) ? ReqSetFeat : ReqClrFeat, 0,
                          ($urandom_range(0, 1) != 0) ? 16'h81 : 16'h01, 0);
      6: return setup_pkt(8'h80 | 8'($urandom_range(0, 2)), ReqGetStatus, 0,
                          16'(($urandom_range(0, 3)) == 0 ? 16'h80 : 16'h81 * $urandom_range(0, 1)
                              | ($urandom_range(0, 1) ? 16'h01 : 16'h00)), 2);
      7: return setup_pkt(8'h80, ReqGetCfg, 0, 0, 16'($urandom_range(0, 2)));
      default: return setup_pkt(8'h81, ($urandom_range(0, 1) != 0) ? ReqGetIf : ReqSetIf, 0, 0,
                                16'($urandom_range(0, 1)));
    endcase
  endfunction

  task automatic random_phase(input int count, input bit gaps);
    event_t e;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: e = plain_op(OpSetup);                 // pure noise
        1: begin
          e = random_request();
          e.rx_length = 7'($urandom);             // usually a broken setup length
        end
        2: e = plain_op(OpOut);
        3: e = plain_op(($urandom_range(0, 5) == 0) ? OpReset : OpIn);
        default: e = random_request();
      endcase
      send_event(e, gaps);
      // Follow a setup event with IN packets most of the time.
      if (e.operation == OpSetup && $urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 5)) send_event(plain_op(OpIn), gaps);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    evt_ch.valid = 1'b0;
    evt_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    stall_enable = 1'b0;
    long_hold = 1'b0;
    events_sent = 0;
    cfg_writes = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on the reset register values.
    send_event(setup_pkt(8'h80, ReqGetDesc, 16'h0100, 0, 16'hFFFF), 0);
    repeat (3) send_event(plain_op(OpIn), 0);
    send_event(plain_op(OpOut), 0);
    send_event(setup_pkt(8'h80, ReqGetDesc, 16'h0303, 0, 16'd40), 0);
    repeat (4) send_event(plain_op(OpIn), 0);
    send_event(setup_pkt(8'h00, ReqSetAddr, 16'h00FF, 0, 0), 0);
    repeat (2) send_event(plain_op(OpIn), 0);
    send_event(setup_pkt(8'h02, ReqSetFeat, 0, 16'h81, 0), 0);  // stalls, not configured
    send_event(plain_op(OpOut), 0);
    send_event(setup_pkt(8'h00, ReqSetCfg, 16'h0001, 0, 0), 0);
    send_event(setup_pkt(8'h02, ReqSetFeat, 0, 16'h81, 0), 0);
    send_event(setup_pkt(8'h82, ReqGetStatus, 0, 16'h81, 2), 0);
    send_event(setup_pkt(8'h02, ReqClrFeat, 0, 16'h81, 0), 0);
    send_event(setup_pkt(8'h81, ReqGetStatus, 0, 0, 2), 0);
    send_event(setup_pkt(8'h80, ReqGetCfg, 0, 0, 1), 0);
    send_event(setup_pkt(8'h01, ReqSetIf, 0, 0, 0), 0);
    send_event(setup_pkt(8'h60, ReqGetDesc, 16'h0100, 0, 8), 0);  // reserved type stalls
    send_event(setup_pkt(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    send_event('{OpSetup, 7'h7F, 8'h80, ReqGetDesc, 16'h0100, 0, 8}, 0);
    send_event(plain_op(OpReset), 0);
    wait_quiet();

    // Extreme register settings, serial string with a request length past its end.
    write_reg(RegDevLen, 40'd255);
    write_reg(RegCfgLen, 40'd0);
    write_reg(RegLangLen, 40'd255);
    write_reg(RegProdLen, 40'd1);
    write_reg(RegRepLen, 40'd255);
    write_reg(RegChipId, 40'hFF_FFFF_FFFF);
    stall_enable = 1'b1;
    send_event(setup_pkt(8'h80, ReqGetDesc, 16'h0303, 0, 16'hFFFF), 1);
    repeat (5) send_event(plain_op(OpIn), 1);
    random_phase(RandomEvents / 4, 1);
    wait_quiet();

    // Long receiver hold-off while events keep coming, then a full drain.
    write_reg(RegChipId, 40'h01_2345_6789);
    write_reg(RegDevLen, 40'd0);
    write_reg(RegRepLen, 40'd9);
    long_hold = 1'b1;
    random_phase(RandomEvents / 8, 0);
    wait_quiet();

    write_reg(RegDevLen, 40'd18);
    write_reg(RegCfgLen, 40'd34);
    write_reg(RegLangLen, 40'd4);
    write_reg(RegProdLen, 40'd24);
    write_reg(RegRepLen, 40'd63);
    write_reg(RegChipId, {$urandom, $urandom} & 40'hFF_FFFF_FFFF);
    random_phase(RandomEvents / 2, 1);
    wait_quiet();

    // Last stretch runs without any idling.
    stall_enable = 1'b0;
    random_phase(RandomEvents / 8, 0);
    wait_quiet();

    $display("Sent %0d events and %0d register writes, checked %0d result items.",
             events_sent, cfg_writes, results_seen);
    if (fail_count == 0) begin
      $display("usb_control_endpoint_handler_unit test passed");
    end else begin
      $display("usb_control_endpoint_handler_unit test failed");
    end
    $finish;
  end

endmodule
